// ===== hw/rtl/gcd_pkg.sv =====
// Shared constants and types for the graph cycle detector.
package gcd_pkg;
   localparam int NodesDefault = 32;

   localparam logic [1:0] ACT_SET   = 2'd0;
   localparam logic [1:0] ACT_CLR   = 2'd1;
   localparam logic [1:0] ACT_CHK   = 2'd2;
   localparam logic [1:0] ACT_CLAIM = 2'd3;

   localparam logic [1:0] MARK_WHITE = 2'd0;
   localparam logic [1:0] MARK_GRAY  = 2'd1;
   localparam logic [1:0] MARK_BLACK = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch item fields and apply edge write
      logic clr_marks; // whiten all marks, empty the stack
      logic root_step; // try to open the current root
      logic dfs_step;  // one scan step on the stack top
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_query;
      logic roots_done;
      logic stack_empty;
      logic found;
   } stat_type;
endpackage

// ===== hw/rtl/gcd_datapath.sv =====
// Datapath: adjacency matrix, marks, DFS stack and find-first scan.
module gcd_datapath import gcd_pkg::*; #(
   parameter int NODES = NodesDefault,
   localparam int NW = $clog2(NODES),
   localparam int CW = $clog2(NODES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [5:0]     node_count,
   input  logic [1:0]     req_action,
   input  logic [4:0]     req_src_node,
   input  logic [4:0]     req_dst_node,
   input  cmd_type        cmd,
   output stat_type       stat
);
   logic [NODES-1:0] adj_ff [NODES];
   logic [1:0]       mark_ff [NODES];
   logic [NW-1:0]    stk_node_ff [NODES];
   logic [NODES-1:0] stk_mask_ff [NODES]; // remaining successors per level
   logic [CW-1:0]    depth_ff;
   logic [1:0]       act_ff;
   logic [4:0]       src_ff, dst_ff;
   logic [CW-1:0]    root_ff;
   logic             found_ff;

   logic [CW-1:0]    cnt;
   logic [NODES-1:0] live;
   logic [NW-1:0]    top_idx, u, v;
   logic [NODES-1:0] row, rem;
   logic             any;

   always_comb begin
      cnt = (int'(node_count) > NODES) ? CW'(NODES) : CW'(node_count);
      for (int i = 0; i < NODES; i++) live[i] = (i < int'(cnt));
      top_idx = NW'(depth_ff - CW'(1));
      u = stk_node_ff[top_idx];
      rem = stk_mask_ff[top_idx];
      any = |rem;
      v = '0;
      for (int i = NODES - 1; i >= 0; i--) if (rem[i]) v = NW'(i);
   end

   // live row of a node, with the claim edge folded in
   function automatic logic [NODES-1:0] live_row(input logic [NW-1:0] n);
      logic [NODES-1:0] r;
      r = adj_ff[n];
      if (act_ff == ACT_CLAIM && 32'(n) == 32'(src_ff) && 32'(dst_ff) < NODES)
         r[NW'(dst_ff)] = 1'b1;
      return r & live;
   endfunction

   assign row = live_row(NW'(root_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) adj_ff[i] <= '0;
         depth_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            act_ff <= req_action;
            src_ff <= req_src_node;
            dst_ff <= req_dst_node;
            found_ff <= 1'b0;
            if ((req_action == ACT_SET || req_action == ACT_CLR) &&
                32'(req_src_node) < NODES && 32'(req_dst_node) < NODES)
               adj_ff[NW'(req_src_node)][NW'(req_dst_node)] <=
                  (req_action == ACT_SET);
         end
         if (cmd.clr_marks) begin
            for (int i = 0; i < NODES; i++) mark_ff[i] <= MARK_WHITE;
            depth_ff <= '0;
            root_ff <= '0;
         end
         if (cmd.root_step) begin
            if (mark_ff[NW'(root_ff)] == MARK_WHITE) begin
               mark_ff[NW'(root_ff)] <= MARK_GRAY;
               stk_node_ff[0] <= NW'(root_ff);
               stk_mask_ff[0] <= row;
               depth_ff <= CW'(1);
            end
            root_ff <= root_ff + CW'(1);
         end
         if (cmd.dfs_step) begin
            if (!any) begin
               mark_ff[u] <= MARK_BLACK;
               depth_ff <= depth_ff - CW'(1);
            end else begin
               stk_mask_ff[top_idx][v] <= 1'b0;
               if (mark_ff[v] == MARK_GRAY) begin
                  found_ff <= 1'b1;
                  depth_ff <= '0;
               end else if (mark_ff[v] == MARK_WHITE) begin
                  mark_ff[v] <= MARK_GRAY;
                  stk_node_ff[NW'(depth_ff)] <= v;
                  stk_mask_ff[NW'(depth_ff)] <= live_row(v);
                  depth_ff <= depth_ff + CW'(1);
               end
            end
         end
      end
   end

   assign stat.is_query    = act_ff[1];
   assign stat.roots_done  = (root_ff >= cnt);
   assign stat.stack_empty = (depth_ff == '0);
   assign stat.found       = found_ff;
endmodule

// ===== hw/rtl/gcd_ctrl.sv =====
// Controller: sequences edge writes and the DFS search.
module gcd_ctrl import gcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid,
   output logic     rsp_has_cycle
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_ROOT = 3'd2;
   localparam logic [2:0] S_DFS  = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in, hc_ff, hc_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      vld_in = 1'b0;
      hc_in = hc_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (stat.is_query) begin
               cmd.clr_marks = 1'b1;
               state_in = S_ROOT;
            end else state_in = S_IDLE;
         end
         S_ROOT: begin
            if (stat.roots_done) begin
               vld_in = 1'b1;
               hc_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               cmd.root_step = 1'b1;
               state_in = S_DFS;
            end
         end
         S_DFS: begin
            if (stat.found) begin
               vld_in = 1'b1;
               hc_in = 1'b1;
               state_in = S_IDLE;
            end else if (stat.stack_empty) state_in = S_ROOT;
            else cmd.dfs_step = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
      hc_ff <= hc_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_has_cycle = hc_ff;
endmodule

// ===== hw/rtl/graph_cycle_detector.sv =====
// Top level of the directed-graph cycle detector.
//
//  channel  ports                               transfer when
//  request  start, busy, req_action/src/dst     start & !busy
//  result   rsp_valid, rsp_has_cycle            rsp_valid (one cycle)
//  config   csr_we, csr_wdata                   csr_we
//
// Edge set/clear: busy for the decode state after the transfer, no result.
// Query: busy for the decode state, then a root try (S_ROOT) and an
// empty-stack check (S_DFS) per root index below node_count, an S_DFS step
// per pop and per live edge scanned in the single DFS scan unit, and a
// closing S_ROOT check; a cycle hit ends the search early. The result strobes in the first cycle busy is low.
// Synchronous reset clears the matrix and sets node_count to 32.
// The receiver cannot stall; results are never held.
module graph_cycle_detector import gcd_pkg::*; #(
   parameter int NODES = NodesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [4:0] req_src_node,
   input  logic [4:0] req_dst_node,
   output logic       rsp_valid,
   output logic       rsp_has_cycle,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata
);
   logic [5:0] node_count_ff;
   cmd_type    cmd;
   stat_type   stat;

   // node_count register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= 6'd32;
      else if (csr_we) node_count_ff <= csr_wdata;
   end

   gcd_datapath #(.NODES(NODES)) u_dp (
      .clock, .reset, .node_count(node_count_ff),
      .req_action, .req_src_node, .req_dst_node, .cmd, .stat
   );

   gcd_ctrl u_ctrl (
      .clock, .reset, .start, .stat, .cmd, .busy, .rsp_valid, .rsp_has_cycle
   );
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the graph cycle detector: edge writes, cycle queries and claim queries.
`timescale 1ns / 100ps

module tb_top;
   import gcd_pkg::*;

   localparam int NodeMax = 32;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = ACT_SET;
   logic [4:0] req_src_node = '0;
   logic [4:0] req_dst_node = '0;
   logic       rsp_valid;
   logic       rsp_has_cycle;
   logic       csr_we = 1'b0;
   logic [5:0] csr_wdata = '0;

   graph_cycle_detector uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_src_node(req_src_node),
      .req_dst_node(req_dst_node), .rsp_valid(rsp_valid),
      .rsp_has_cycle(rsp_has_cycle), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state: our own copy of the edge matrix and node count.
   logic [NodeMax-1:0] edge_rows [NodeMax];
   logic [5:0]         live_nodes;
   bit                 cycle_answers [$];
   int                 fail_count = 0;
   int                 burst_left = 0;

   // Depth-first search with white/gray/black marks over the live nodes.
   // The claim edge is ORed into a copy of its row for this query only.
   function automatic bit predict_cycle(bit claim, int csrc, int cdst);
      logic [NodeMax-1:0] live;
      logic [NodeMax-1:0] row;
      logic [1:0]         mark [NodeMax];
      int                 stk_node [NodeMax];
      int                 stk_cur [NodeMax];
      int                 depth;
      int                 cnt;
      int                 u;
      int                 v;
      cnt = (live_nodes > NodeMax) ? NodeMax : int'(live_nodes);
      live = (cnt >= NodeMax) ? '1 : ((NodeMax'(1) << cnt) - 1);
      for (int i = 0; i < NodeMax; i++) mark[i] = MARK_WHITE;
      for (int root = 0; root < cnt; root++) begin
         if (mark[root] != MARK_WHITE) continue;
         mark[root] = MARK_GRAY;
         stk_node[0] = root;
         stk_cur[0] = 0;
         depth = 1;
         while (depth > 0) begin
            u = stk_node[depth-1];
            row = edge_rows[u];
            if (claim && u == csrc) row[cdst] = 1'b1;
            row &= live;
            row &= ('1 << stk_cur[depth-1]);
            if (stk_cur[depth-1] >= NodeMax) row = '0;
            if (row == '0) begin
               mark[u] = MARK_BLACK;
               depth--;
               continue;
            end
            v = 0;
            while (!row[v]) v++;
            stk_cur[depth-1] = v + 1;
            if (mark[v] == MARK_GRAY) return 1'b1;
            if (mark[v] == MARK_WHITE) begin
               mark[v] = MARK_GRAY;
               stk_node[depth] = v;
               stk_cur[depth] = 0;
               depth++;
            end
         end
      end
      return 1'b0;
   endfunction

   // Sender: bursts of random length, random gaps between them.
   // start stays high inside a burst; it drops only for a gap or when idling.
   task automatic send_item(logic [1:0] act, logic [4:0] src, logic [4:0] dst);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_action <= act;
      req_src_node <= src;
      req_dst_node <= dst;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer taken at this edge: update the predictor
      case (act)
         ACT_SET: edge_rows[src][dst] = 1'b1;
         ACT_CLR: edge_rows[src][dst] = 1'b0;
         ACT_CHK: cycle_answers.push_back(predict_cycle(1'b0, src, dst));
         default: cycle_answers.push_back(predict_cycle(1'b1, src, dst));
      endcase
      @(negedge clock);
   endtask

   // Drain results, then allow the block to finish a trailing edge write.
   task automatic wait_idle();
      start <= 1'b0;
      while (cycle_answers.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_node_count(logic [5:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      live_nodes = value;
   endtask

   task automatic clear_graph(output int sent);
      sent = 0;
      for (int s = 0; s < NodeMax; s++)
         for (int d = 0; d < NodeMax; d++)
            if (edge_rows[s][d]) begin
               send_item(ACT_CLR, 5'(s), 5'(d));
               sent++;
            end
   endtask

   // Directed: empty graph, self loops, extremes, claim edges, node count edges.
   task automatic test_directed();
      int cleared;
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_CLAIM, 5'd31, 5'd31);       // self loop as claim
      send_item(ACT_CHK, 5'd0, 5'd0);           // claim must not stick
      send_item(ACT_SET, 5'd0, 5'd31);
      send_item(ACT_SET, 5'd31, 5'd0);
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_CLR, 5'd31, 5'd0);
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_CLAIM, 5'd31, 5'd0);
      send_item(ACT_SET, 5'd5, 5'd5);
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_CLAIM, 5'd5, 5'd5);         // claim on an existing edge
      send_item(ACT_CLR, 5'd5, 5'd5);
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_SET, 5'd3, 5'd3);
      write_node_count(6'd3);                   // loop at node 3 now ignored
      send_item(ACT_CHK, 5'd0, 5'd0);
      send_item(ACT_CLAIM, 5'd2, 5'd3);
      send_item(ACT_CLAIM, 5'd2, 5'd2);
      write_node_count(6'd0);
      send_item(ACT_CLAIM, 5'd0, 5'd0);
      write_node_count(6'd63);                  // above NODES: all 32 used
      send_item(ACT_CHK, 5'd21, 5'd10);
      write_node_count(6'd1);
      send_item(ACT_CLAIM, 5'd0, 5'd0);
      clear_graph(cleared);
   endtask

   // Random: mostly chains and rings over a small window, plus noise.
   task automatic test_random(int items, logic [5:0] count);
      int base;
      int len;
      int cleared;
      write_node_count(count);
      while (items > 0) begin
         if ($urandom_range(0, 3) != 0) begin
            base = $urandom_range(0, 31);
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_item(ACT_SET, 5'(base + i), 5'(base + i + 1));
            send_item(ACT_CHK, 5'($urandom), 5'($urandom));
            send_item(ACT_CLAIM, 5'(base + len), 5'(base + $urandom_range(0, len)));
            if ($urandom_range(0, 1)) send_item(ACT_CLR, 5'(base), 5'(base + 1));
            items -= len + 3;
         end else begin
            send_item(2'($urandom), 5'($urandom), 5'($urandom));
            items--;
         end
         if ($urandom_range(0, 9) == 0) begin
            clear_graph(cleared);
            items -= cleared;
         end
      end
      clear_graph(cleared);
   endtask

   // Result checker: one strobe, one expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (cycle_answers.size() == 0) begin
            $error("has_cycle: unexpected result, actual %0b", rsp_has_cycle);
            fail_count++;
         end else begin
            bit want;
            want = cycle_answers.pop_front();
            if (rsp_has_cycle !== want) begin
               $error("has_cycle: expected %0b actual %0b", want, rsp_has_cycle);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NodeMax; i++) edge_rows[i] = '0;
      live_nodes = 6'd32;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(130, 6'd32);
      test_random(100, 6'd8);
      test_random(90, 6'd17);
      test_random(90, 6'd2);
      wait_idle();
      if (fail_count == 0 && cycle_answers.size() == 0)
         $display("PASS graph_cycle_detector");
      else
         $display("FAIL graph_cycle_detector");
      $finish;
   end

   // Watchdog
   initial begin
      #10000000;
      $display("FAIL graph_cycle_detector");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_datapath.sv
hw/rtl/gcd_ctrl.sv
hw/rtl/graph_cycle_detector.sv
sim/tb_top.sv
